// ----- rtl/hysteresis_cooling_controller_defines.svh -----
// assertion macros used by the checker file
`ifndef HYSTERESIS_COOLING_CONTROLLER_DEFINES_SVH
`define HYSTERESIS_COOLING_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define HCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcc assertion failed");

// next-cycle implication, disabled while reset is held
`define HCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcc assertion failed");

`endif

// ----- rtl/hcc_pkg.sv -----
// types and constants of the cooling controller
package hcc_pkg;

  // event codes carried by req_type
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_BUTTON = 2'd1;
  localparam logic [1:0] REQ_TEMP   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_HYST     = 3'd0;
  localparam logic [2:0] REG_STEP     = 3'd1;
  localparam logic [2:0] REG_SP_MIN   = 3'd2;
  localparam logic [2:0] REG_SP_MAX   = 3'd3;
  localparam logic [2:0] REG_SP_INIT  = 3'd4;
  localparam logic [2:0] REG_LIGHT_MS = 3'd5;
  localparam logic [2:0] REG_IDLE_MS  = 3'd6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // register reset values
  localparam logic [9:0]  HYST_RST     = 10'd32;
  localparam logic [7:0]  STEP_RST     = 8'd16;
  localparam logic [10:0] SP_MIN_RST   = 11'd0;
  localparam logic [10:0] SP_MAX_RST   = 11'd480;
  localparam logic [10:0] SP_INIT_RST  = 11'd80;
  localparam logic [23:0] LIGHT_MS_RST = 24'd10000;
  localparam logic [23:0] IDLE_MS_RST  = 24'd300000;

  typedef struct packed {
    logic [9:0]  hysteresis;
    logic [7:0]  setpoint_step;
    logic [10:0] setpoint_min;
    logic [10:0] setpoint_max;
    logic [23:0] light_time_ms;
    logic [23:0] idle_timeout_ms;
  } cfg_t;

  // setpoint load caused by a write of the initial setpoint
  typedef struct packed {
    logic        load;
    logic [10:0] value;
  } sp_load_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic               key_down;
    logic               key_up;
    logic               key_stop;
    logic               key_start;
    logic signed [11:0] temp_reading;
    logic               sensor_lost;
  } item_t;

  typedef struct packed {
    logic               cooler_on;
    logic               light_on;
    logic               display_asleep;
    logic               running;
    logic [10:0]        setpoint_now;
    logic signed [11:0] temp_now;
    logic               temp_known;
    logic [2:0]         beep_count;
  } result_t;

endpackage

// ----- rtl/hysteresis_cooling_controller.sv -----
// Bang-bang cooling controller with hysteresis, one event per beat.
// Path: input register, then state update and result register.
// Throughput: one event per cycle unless out_ready stalls; the state update of one
// event is a single registered step, so the next event follows directly behind it.
// Reset (rst_n low, synchronous): registers to their defaults, setpoint to 80.
module hysteresis_cooling_controller #(
  parameter int TIMER_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  // event channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic               in_key_down,
  input  logic               in_key_up,
  input  logic               in_key_stop,
  input  logic               in_key_start,
  input  logic signed [11:0] in_temp_reading,
  input  logic               in_sensor_lost,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_cooler_on,
  output logic               out_light_on,
  output logic               out_display_asleep,
  output logic               out_running,
  output logic [10:0]        out_setpoint_now,
  output logic signed [11:0] out_temp_now,
  output logic               out_temp_known,
  output logic [2:0]         out_beep_count,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  hcc_pkg::item_t    item_r;
  logic              item_vld_r;
  hcc_pkg::result_t  res_r;
  hcc_pkg::result_t  res_nxt;
  logic              out_vld_r;
  logic              fire;
  hcc_pkg::cfg_t     cfg;
  hcc_pkg::sp_load_t sp_load;

  assign cfg_ready = 1'b1;

  hcc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg),
    .sp_load (sp_load)
  );

  // step the held event when the result register is free or draining
  assign fire     = item_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !item_vld_r || fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.req_type     <= in_req_type;
      item_r.key_down     <= in_key_down;
      item_r.key_up       <= in_key_up;
      item_r.key_stop     <= in_key_stop;
      item_r.key_start    <= in_key_start;
      item_r.temp_reading <= in_temp_reading;
      item_r.sensor_lost  <= in_sensor_lost;
    end
  end

  hcc_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .item    (item_r),
    .cfg     (cfg),
    .sp_load (sp_load),
    .res     (res_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_cooler_on      = res_r.cooler_on;
  assign out_light_on       = res_r.light_on;
  assign out_display_asleep = res_r.display_asleep;
  assign out_running        = res_r.running;
  assign out_setpoint_now   = res_r.setpoint_now;
  assign out_temp_now       = res_r.temp_now;
  assign out_temp_known     = res_r.temp_known;
  assign out_beep_count     = res_r.beep_count;

endmodule

// ----- rtl/hcc_cfg.sv -----
// configuration register file of the cooling controller
module hcc_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [hcc_pkg::CFG_IDX_W-1:0]       wr_idx,
  input  logic [hcc_pkg::CFG_DATA_W-1:0]      wr_data,
  output hcc_pkg::cfg_t                       cfg,
  output hcc_pkg::sp_load_t                   sp_load
);

  hcc_pkg::cfg_t cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hysteresis      <= hcc_pkg::HYST_RST;
      cfg_r.setpoint_step   <= hcc_pkg::STEP_RST;
      cfg_r.setpoint_min    <= hcc_pkg::SP_MIN_RST;
      cfg_r.setpoint_max    <= hcc_pkg::SP_MAX_RST;
      cfg_r.light_time_ms   <= hcc_pkg::LIGHT_MS_RST;
      cfg_r.idle_timeout_ms <= hcc_pkg::IDLE_MS_RST;
    end else if (wr_en) begin
      unique case (wr_idx)
        hcc_pkg::REG_HYST:     cfg_r.hysteresis      <= wr_data[9:0];
        hcc_pkg::REG_STEP:     cfg_r.setpoint_step   <= wr_data[7:0];
        hcc_pkg::REG_SP_MIN:   cfg_r.setpoint_min    <= wr_data[10:0];
        hcc_pkg::REG_SP_MAX:   cfg_r.setpoint_max    <= wr_data[10:0];
        hcc_pkg::REG_LIGHT_MS: cfg_r.light_time_ms   <= wr_data[23:0];
        hcc_pkg::REG_IDLE_MS:  cfg_r.idle_timeout_ms <= wr_data[23:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

  // the initial setpoint register lives in the state block as the setpoint itself
  assign sp_load.load  = wr_en && (wr_idx == hcc_pkg::REG_SP_INIT);
  assign sp_load.value = wr_data[10:0];

endmodule

// ----- rtl/hcc_step.sv -----
// controller state and the per-event next-state logic
module hcc_step #(
  parameter int TIMER_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  hcc_pkg::item_t    item,
  input  hcc_pkg::cfg_t     cfg,
  input  hcc_pkg::sp_load_t sp_load,
  output hcc_pkg::result_t  res
);

  // compare width covering both counter and limit
  localparam int CW = (TIMER_BITS > 24) ? TIMER_BITS : 24;

  logic [10:0]           sp_r, sp_nxt;
  logic signed [11:0]    temp_r, temp_nxt;
  logic                  have_temp_r, have_temp_nxt;
  logic                  cooling_r, cooling_nxt;
  logic                  started_r, started_nxt;
  logic                  light_act_r, light_act_nxt;
  logic [TIMER_BITS-1:0] light_cnt_r, light_cnt_nxt;
  logic                  asleep_r, asleep_nxt;
  logic [TIMER_BITS-1:0] idle_cnt_r, idle_cnt_nxt;
  logic [2:0]            beeps_nxt;

  logic [12:0]           dn_diff;
  logic [10:0]           sp_dn;
  logic [11:0]           up_sum;
  logic [10:0]           sp_up;
  logic [11:0]           on_sum;
  logic signed [13:0]    temp_ext;
  logic signed [13:0]    sp_ext;
  logic signed [13:0]    on_thr;
  logic                  any_btn;

  // down press: subtract step, raise to the minimum
  always_comb begin
    dn_diff = {2'b00, sp_r} - {5'd0, cfg.setpoint_step};
    sp_dn   = ($signed(dn_diff) < $signed({2'b00, cfg.setpoint_min})) ?
              cfg.setpoint_min : dn_diff[10:0];
  end

  // up press applied after down: add step, lower to the maximum
  always_comb begin
    up_sum = {1'b0, (item.key_down ? sp_dn : sp_r)} + {4'd0, cfg.setpoint_step};
    sp_up  = (up_sum > {1'b0, cfg.setpoint_max}) ? cfg.setpoint_max : up_sum[10:0];
  end

  // hysteresis thresholds against the reading in effect for this event
  always_comb begin
    temp_ext = item.sensor_lost ? 14'(temp_r) : 14'(item.temp_reading);
    sp_ext   = $signed({3'b000, sp_r});
    on_sum   = {1'b0, sp_r} + {2'b00, cfg.hysteresis};
    on_thr   = $signed({2'b00, on_sum});
  end

  assign any_btn = item.key_down | item.key_up | item.key_stop | item.key_start;

  // next state for one event
  always_comb begin
    sp_nxt        = sp_r;
    temp_nxt      = temp_r;
    have_temp_nxt = have_temp_r;
    cooling_nxt   = cooling_r;
    started_nxt   = started_r;
    light_act_nxt = light_act_r;
    light_cnt_nxt = light_cnt_r;
    asleep_nxt    = asleep_r;
    idle_cnt_nxt  = idle_cnt_r;
    beeps_nxt     = 3'd0;

    unique case (item.req_type)
      hcc_pkg::REQ_TICK: begin
        if (light_act_r) begin
          light_cnt_nxt = (&light_cnt_r) ? light_cnt_r : light_cnt_r + 1'b1;
          if (CW'(light_cnt_nxt) >= CW'(cfg.light_time_ms)) begin
            light_act_nxt = 1'b0;
          end
        end
        idle_cnt_nxt = (&idle_cnt_r) ? idle_cnt_r : idle_cnt_r + 1'b1;
        if (!asleep_r && (CW'(idle_cnt_nxt) >= CW'(cfg.idle_timeout_ms))) begin
          asleep_nxt = 1'b1;
        end
      end
      hcc_pkg::REQ_BUTTON: begin
        if (asleep_r) begin
          // a press only wakes the display
          if (any_btn) begin
            asleep_nxt   = 1'b0;
            idle_cnt_nxt = '0;
          end
        end else begin
          if (item.key_down) begin
            sp_nxt = sp_dn;
          end
          if (item.key_up) begin
            sp_nxt = sp_up;
          end
          if (item.key_stop) begin
            cooling_nxt = 1'b0;
            started_nxt = 1'b0;
          end
          if (item.key_start) begin
            started_nxt   = 1'b1;
            cooling_nxt   = 1'b1;
            light_act_nxt = 1'b1;
            light_cnt_nxt = '0;
          end
          if (any_btn) begin
            idle_cnt_nxt = '0;
          end
          beeps_nxt = {2'b00, item.key_down} + {2'b00, item.key_up} +
                      {2'b00, item.key_stop} + {2'b00, item.key_start};
        end
      end
      hcc_pkg::REQ_TEMP: begin
        if (!item.sensor_lost) begin
          temp_nxt      = item.temp_reading;
          have_temp_nxt = 1'b1;
        end
        if (!started_r) begin
          cooling_nxt = 1'b0;
        end else if (have_temp_nxt) begin
          if (cooling_r) begin
            if (temp_ext <= sp_ext) cooling_nxt = 1'b0;
          end else begin
            if (temp_ext >= on_thr) cooling_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= hcc_pkg::SP_INIT_RST;
      temp_r      <= '0;
      have_temp_r <= 1'b0;
      cooling_r   <= 1'b0;
      started_r   <= 1'b0;
      light_act_r <= 1'b0;
      light_cnt_r <= '0;
      asleep_r    <= 1'b0;
      idle_cnt_r  <= '0;
    end else begin
      // a write of the initial setpoint reloads the live setpoint
      if (sp_load.load) begin
        sp_r <= sp_load.value;
      end else if (fire) begin
        sp_r <= sp_nxt;
      end
      if (fire) begin
        temp_r      <= temp_nxt;
        have_temp_r <= have_temp_nxt;
        cooling_r   <= cooling_nxt;
        started_r   <= started_nxt;
        light_act_r <= light_act_nxt;
        light_cnt_r <= light_cnt_nxt;
        asleep_r    <= asleep_nxt;
        idle_cnt_r  <= idle_cnt_nxt;
      end
    end
  end

  // result of this event
  always_comb begin
    res.cooler_on      = cooling_nxt;
    res.light_on       = light_act_nxt;
    res.display_asleep = asleep_nxt;
    res.running        = started_nxt;
    res.setpoint_now   = sp_nxt;
    res.temp_now       = temp_nxt;
    res.temp_known     = have_temp_nxt;
    res.beep_count     = beeps_nxt;
  end

endmodule

// ----- rtl/hcc_checker.sv -----
// port-level checks of the cooling controller and their bind
`include "hysteresis_cooling_controller_defines.svh"

module hcc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_cooler_on,
  input logic               out_light_on,
  input logic               out_display_asleep,
  input logic               out_running,
  input logic [10:0]        out_setpoint_now,
  input logic signed [11:0] out_temp_now,
  input logic               out_temp_known,
  input logic [2:0]         out_beep_count
);

  // whole result payload
  logic [30:0] out_payload;

  assign out_payload = {out_cooler_on, out_light_on, out_display_asleep, out_running,
                        out_setpoint_now, out_temp_now, out_temp_known, out_beep_count};

  // a stalled result beat holds its payload
  `HCC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_payload))

  // the cooler only runs while the system is started
  `HCC_ASSERT_IMPL(a_cool_needs_run, clk, rst_n, out_valid && out_cooler_on, out_running)

  // at most one beep per button
  `HCC_ASSERT_IMPL(a_beep_range, clk, rst_n, out_valid, out_beep_count <= 3'd4)

  // a sleeping display never reports executed functions
  `HCC_ASSERT_IMPL(a_sleep_no_beep, clk, rst_n, out_valid && out_display_asleep, out_beep_count == 3'd0)

  // once a reading is known it stays known
  `HCC_ASSERT_NEXT(a_temp_sticky, clk, rst_n, out_valid && out_ready && out_temp_known, !out_valid || out_temp_known)

endmodule

bind hysteresis_cooling_controller hcc_checker u_hcc_checker (.*);

// ----- tb/sv/hysteresis_cooling_controller_test.sv -----
// self-checking test of the cooling controller: predicted status beats vs. block output
module hysteresis_cooling_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD       = 10;
  localparam int PHASES           = 7;
  localparam int ITEMS_PER_PHASE  = 230;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES     = 8;
  localparam int RUN_LIMIT_NS     = 3_000_000;
  localparam int MAX_REPORTS      = 10;

  // req_type code the block ignores
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // predicted controller plus the queue of status beats still owed by the block
  class cooler_scoreboard;
    logic [9:0]         hyst;
    logic [7:0]         step;
    logic [10:0]        sp_min;
    logic [10:0]        sp_max;
    logic [10:0]        sp_init;
    logic [23:0]        light_ms;
    logic [23:0]        idle_ms;
    logic [10:0]        setpoint;
    logic signed [11:0] inside_temp;
    logic               have_temp;
    logic               cooling;
    logic               started;
    logic               light_active;
    logic               asleep;
    logic [23:0]        light_elapsed;
    logic [23:0]        idle_elapsed;
    hcc_pkg::result_t   pending_status[$];
    int                 failures;

    function new();
      failures = 0;
      restore_defaults();
    endfunction

    function void restore_defaults();
      hyst          = hcc_pkg::HYST_RST;
      step          = hcc_pkg::STEP_RST;
      sp_min        = hcc_pkg::SP_MIN_RST;
      sp_max        = hcc_pkg::SP_MAX_RST;
      sp_init       = hcc_pkg::SP_INIT_RST;
      light_ms      = hcc_pkg::LIGHT_MS_RST;
      idle_ms       = hcc_pkg::IDLE_MS_RST;
      setpoint      = hcc_pkg::SP_INIT_RST;
      inside_temp   = '0;
      have_temp     = 1'b0;
      cooling       = 1'b0;
      started       = 1'b0;
      light_active  = 1'b0;
      asleep        = 1'b0;
      light_elapsed = '0;
      idle_elapsed  = '0;
    endfunction

    function void load_register(logic [2:0] idx, logic [23:0] data);
      case (idx)
        hcc_pkg::REG_HYST:     hyst = data[9:0];
        hcc_pkg::REG_STEP:     step = data[7:0];
        hcc_pkg::REG_SP_MIN:   sp_min = data[10:0];
        hcc_pkg::REG_SP_MAX:   sp_max = data[10:0];
        // writing the initial setpoint also loads the live one
        hcc_pkg::REG_SP_INIT: begin
          sp_init  = data[10:0];
          setpoint = data[10:0];
        end
        hcc_pkg::REG_LIGHT_MS: light_ms = data;
        hcc_pkg::REG_IDLE_MS:  idle_ms = data;
        default: ;
      endcase
    endfunction

    // saturating millisecond counter
    static function logic [23:0] timer_step(logic [23:0] v);
      return (v == '1) ? v : v + 24'd1;
    endfunction

    // run one accepted event through the controller and queue its status
    function void note_event(hcc_pkg::item_t ev);
      hcc_pkg::result_t r;
      logic [2:0]       beeps;
      int               s;
      int               temp_i;
      int               sp_i;
      beeps = '0;
      case (ev.req_type)
        hcc_pkg::REQ_TICK: begin
          if (light_active) begin
            light_elapsed = timer_step(light_elapsed);
            if (light_elapsed >= light_ms) light_active = 1'b0;
          end
          idle_elapsed = timer_step(idle_elapsed);
          if (!asleep && idle_elapsed >= idle_ms) asleep = 1'b1;
        end
        hcc_pkg::REQ_BUTTON: begin
          if (asleep) begin
            // a sleeping display only wakes up
            if (ev.key_down || ev.key_up || ev.key_stop || ev.key_start) begin
              asleep       = 1'b0;
              idle_elapsed = '0;
            end
          end else begin
            if (ev.key_down) begin
              s = int'(setpoint) - int'(step);
              if (s < int'(sp_min)) s = int'(sp_min);
              setpoint     = 11'(s);
              beeps++;
              idle_elapsed = '0;
            end
            if (ev.key_up) begin
              s = int'(setpoint) + int'(step);
              if (s > int'(sp_max)) s = int'(sp_max);
              setpoint     = 11'(s);
              beeps++;
              idle_elapsed = '0;
            end
            if (ev.key_stop) begin
              cooling      = 1'b0;
              started      = 1'b0;
              beeps++;
              idle_elapsed = '0;
            end
            if (ev.key_start) begin
              started       = 1'b1;
              cooling       = 1'b1;
              light_active  = 1'b1;
              light_elapsed = '0;
              beeps++;
              idle_elapsed  = '0;
            end
          end
        end
        hcc_pkg::REQ_TEMP: begin
          if (!ev.sensor_lost) begin
            inside_temp = ev.temp_reading;
            have_temp   = 1'b1;
          end
          temp_i = inside_temp;
          sp_i   = setpoint;
          // hysteresis band: off at or below setpoint, on at setpoint + hyst
          if (!started) begin
            cooling = 1'b0;
          end else if (have_temp) begin
            if (cooling) begin
              if (temp_i <= sp_i) cooling = 1'b0;
            end else if (temp_i >= sp_i + int'(hyst)) begin
              cooling = 1'b1;
            end
          end
        end
        default: ;
      endcase
      r.cooler_on      = cooling;
      r.light_on       = light_active;
      r.display_asleep = asleep;
      r.running        = started;
      r.setpoint_now   = setpoint;
      r.temp_now       = inside_temp;
      r.temp_known     = have_temp;
      r.beep_count     = beeps;
      pending_status.push_back(r);
    endfunction

    function void compare_field(string name, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected 0x%03h, got 0x%03h", $time, name, want, got);
      end
    endfunction

    function void check_result(hcc_pkg::result_t got);
      hcc_pkg::result_t want;
      if (pending_status.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: status beat with nothing pending", $time);
        return;
      end
      want = pending_status.pop_front();
      compare_field("cooler_on", want.cooler_on, got.cooler_on);
      compare_field("light_on", want.light_on, got.light_on);
      compare_field("display_asleep", want.display_asleep, got.display_asleep);
      compare_field("running", want.running, got.running);
      compare_field("setpoint_now", want.setpoint_now, got.setpoint_now);
      compare_field("temp_now", want.temp_now, got.temp_now);
      compare_field("temp_known", want.temp_known, got.temp_known);
      compare_field("beep_count", want.beep_count, got.beep_count);
    endfunction

    function int pending();
      return pending_status.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_req_type = hcc_pkg::REQ_TICK;
  logic               in_key_down = 1'b0;
  logic               in_key_up = 1'b0;
  logic               in_key_stop = 1'b0;
  logic               in_key_start = 1'b0;
  logic signed [11:0] in_temp_reading = '0;
  logic               in_sensor_lost = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_cooler_on;
  logic               out_light_on;
  logic               out_display_asleep;
  logic               out_running;
  logic [10:0]        out_setpoint_now;
  logic signed [11:0] out_temp_now;
  logic               out_temp_known;
  logic [2:0]         out_beep_count;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = hcc_pkg::REG_HYST;
  logic [23:0]        cfg_data = '0;

  // no idling on either side once set
  bit steady = 1'b0;
  bit long_hold_pending = 1'b0;

  cooler_scoreboard status_board;

  hysteresis_cooling_controller i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_key_down        (in_key_down),
    .in_key_up          (in_key_up),
    .in_key_stop        (in_key_stop),
    .in_key_start       (in_key_start),
    .in_temp_reading    (in_temp_reading),
    .in_sensor_lost     (in_sensor_lost),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_cooler_on      (out_cooler_on),
    .out_light_on       (out_light_on),
    .out_display_asleep (out_display_asleep),
    .out_running        (out_running),
    .out_setpoint_now   (out_setpoint_now),
    .out_temp_now       (out_temp_now),
    .out_temp_known     (out_temp_known),
    .out_beep_count     (out_beep_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic hcc_pkg::item_t make_item(logic [1:0] req, bit down, bit up, bit stop,
                                               bit start, logic signed [11:0] temp, bit lost);
    hcc_pkg::item_t it;
    it.req_type     = req;
    it.key_down     = down;
    it.key_up       = up;
    it.key_stop     = stop;
    it.key_start    = start;
    it.temp_reading = temp;
    it.sensor_lost  = lost;
    return it;
  endfunction

  // random event; unused fields carry noise, temperatures mostly hug the band
  function automatic hcc_pkg::item_t random_event();
    hcc_pkg::item_t it;
    int             pick;
    int             lo;
    int             hi;
    int             t;
    it.key_down     = $urandom_range(0, 1);
    it.key_up       = $urandom_range(0, 1);
    it.key_stop     = $urandom_range(0, 1);
    it.key_start    = $urandom_range(0, 1);
    it.temp_reading = 12'($urandom);
    it.sensor_lost  = $urandom_range(0, 1);
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      it.req_type = hcc_pkg::REQ_TICK;
    end else if (pick < 62) begin
      it.req_type  = hcc_pkg::REQ_BUTTON;
      it.key_down  = ($urandom_range(0, 3) == 0);
      it.key_up    = ($urandom_range(0, 3) == 0);
      it.key_stop  = ($urandom_range(0, 7) == 0);
      it.key_start = ($urandom_range(0, 5) == 0);
    end else if (pick < 96) begin
      it.req_type    = hcc_pkg::REQ_TEMP;
      it.sensor_lost = ($urandom_range(0, 9) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        lo = int'(status_board.setpoint) - 48;
        hi = int'(status_board.setpoint) + int'(status_board.hyst) + 48;
        t  = lo + int'($urandom_range(0, hi - lo));
        if (t > 2047) t = 2047;
        if (t < -2048) t = -2048;
        it.temp_reading = 12'(t);
      end else if (pick < 90) begin
        it.temp_reading = 12'(-880 + int'($urandom_range(0, 2880)));
      end
    end else begin
      it.req_type = REQ_UNUSED;
    end
    return it;
  endfunction

  // offer one event beat and hold it until taken
  task automatic send_event(input hcc_pkg::item_t ev);
    in_valid        <= 1'b1;
    in_req_type     <= ev.req_type;
    in_key_down     <= ev.key_down;
    in_key_up       <= ev.key_up;
    in_key_stop     <= ev.key_stop;
    in_key_start    <= ev.key_start;
    in_temp_reading <= ev.temp_reading;
    in_sensor_lost  <= ev.sensor_lost;
    do @(posedge clk); while (!in_ready);
    status_board.note_event(ev);
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic close_stream();
    in_valid <= 1'b0;
  endtask

  // wait until every owed status beat is back, plus pipeline slack
  task automatic settle();
    while (status_board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    status_board.load_register(idx, data);
  endtask

  task automatic program_registers(input logic [9:0] hyst, input logic [7:0] step,
                                   input logic [10:0] sp_min, input logic [10:0] sp_max,
                                   input logic [10:0] sp_init, input logic [23:0] light_ms,
                                   input logic [23:0] idle_ms);
    write_register(hcc_pkg::REG_HYST, 24'(hyst));
    write_register(hcc_pkg::REG_STEP, 24'(step));
    write_register(hcc_pkg::REG_SP_MIN, 24'(sp_min));
    write_register(hcc_pkg::REG_SP_MAX, 24'(sp_max));
    write_register(hcc_pkg::REG_SP_INIT, 24'(sp_init));
    write_register(hcc_pkg::REG_LIGHT_MS, light_ms);
    write_register(hcc_pkg::REG_IDLE_MS, idle_ms);
    cfg_valid <= 1'b0;
  endtask

  // status sink: random stalls, one long hold-off, none at the end
  initial begin : status_sink
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold_pending) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_pending = 1'b0;
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // compare every accepted status beat
  always @(posedge clk) begin : status_monitor
    hcc_pkg::result_t got;
    if (rst_n && out_valid && out_ready) begin
      got = {out_cooler_on, out_light_on, out_display_asleep, out_running,
             out_setpoint_now, out_temp_now, out_temp_known, out_beep_count};
      status_board.check_result(got);
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    status_board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: stopped cooler, start with no reading, lost sensor, unused code
    send_event(make_item(hcc_pkg::REQ_TEMP, 0, 0, 0, 0, 0, 1));
    send_event(make_item(hcc_pkg::REQ_BUTTON, 0, 0, 0, 1, 0, 0));
    send_event(make_item(hcc_pkg::REQ_TEMP, 0, 0, 0, 0, 2047, 1));
    send_event(make_item(REQ_UNUSED, 1, 1, 1, 1, -1, 1));
    close_stream();
    settle();

    // crossed limits, zero hysteresis, short timers
    program_registers(10'd0, 8'd255, 11'd100, 11'd50, 11'd2047, 24'd2, 24'd4);
    send_event(make_item(hcc_pkg::REQ_BUTTON, 1, 0, 0, 0, 0, 0));
    send_event(make_item(hcc_pkg::REQ_BUTTON, 0, 1, 0, 0, 0, 0));
    send_event(make_item(hcc_pkg::REQ_BUTTON, 1, 0, 0, 0, 0, 0));
    send_event(make_item(hcc_pkg::REQ_BUTTON, 1, 1, 1, 1, 0, 0));
    send_event(make_item(hcc_pkg::REQ_TEMP, 0, 0, 0, 0, 2047, 0));
    send_event(make_item(hcc_pkg::REQ_TEMP, 0, 0, 0, 0, -2048, 0));
    send_event(make_item(hcc_pkg::REQ_TEMP, 0, 0, 0, 0, 50, 0));
    send_event(make_item(hcc_pkg::REQ_TEMP, 0, 0, 0, 0, 50, 0));
    // light expires, then the display sleeps
    send_event(make_item(hcc_pkg::REQ_TICK, 1, 1, 1, 1, -1, 1));
    send_event(make_item(hcc_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0));
    send_event(make_item(hcc_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0));
    send_event(make_item(hcc_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0));
    // asleep: empty sample does nothing, a press only wakes
    send_event(make_item(hcc_pkg::REQ_BUTTON, 0, 0, 0, 0, 0, 0));
    send_event(make_item(hcc_pkg::REQ_BUTTON, 0, 1, 0, 0, 0, 0));
    send_event(make_item(hcc_pkg::REQ_BUTTON, 0, 0, 1, 0, 0, 0));
    send_event(make_item(hcc_pkg::REQ_TEMP, 0, 0, 0, 0, 500, 0));
    send_event(make_item(hcc_pkg::REQ_TEMP, 0, 0, 0, 0, -880, 1));
    send_event(make_item(REQ_UNUSED, 0, 0, 0, 0, 2000, 0));
    close_stream();

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: program_registers(10'd0, 8'd1, 11'd0, 11'd0, 11'd0, 24'd1, 24'd1);
        1: program_registers(10'd800, 8'd160, 11'd2000, 11'd2000, 11'd2000,
                             24'hFFFFFF, 24'hFFFFFF);
        2: program_registers(10'h3FF, 8'hFF, 11'd0, 11'h7FF, 11'h7FF, 24'd5, 24'd30);
        default: program_registers(($urandom_range(0, 5) == 0) ? 10'h3FF
                                     : 10'($urandom_range(0, 800)),
                                   8'($urandom_range(1, 160)),
                                   11'($urandom_range(0, 2000)),
                                   11'($urandom_range(0, 2000)),
                                   11'($urandom_range(0, 2000)),
                                   24'($urandom_range(1, 40)),
                                   24'($urandom_range(8, 90)));
      endcase
      steady = (p == PHASES - 1);
      if (p == 3) long_hold_pending = 1'b1;
      repeat (ITEMS_PER_PHASE) send_event(random_event());
      close_stream();
    end

    settle();
    if (status_board.failures == 0 && status_board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/hcc_pkg.sv
rtl/hcc_cfg.sv
rtl/hcc_step.sv
rtl/hysteresis_cooling_controller.sv
rtl/hcc_checker.sv
tb/sv/hysteresis_cooling_controller_test.sv
